// ===== rtl/hcl_pkg.sv =====
package hcl_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int IDX_W = $clog2(LINE_DEPTH);
  localparam int STEP_W = 4;

  localparam logic [7:0] NEWLINE = 8'h0A;
  localparam logic [7:0] SMALL_CHECK = 8'h55;
  localparam logic [7:0] CMD_FREQ = 8'h66;
  localparam logic [7:0] CMD_PULSE = 8'h74;
  localparam logic [7:0] CMD_SUPPLY = 8'h75;
  localparam logic [7:0] CMD_LOAD = 8'h6C;

  localparam logic [31:0] FREQ_RESET = 32'd20000000;
  localparam logic [31:0] PULSE_RESET = 32'd10000;
  localparam logic [7:0] LEVEL_RESET = 8'd50;
  localparam logic [7:0] LEVEL_MAX = 8'd255;

  localparam logic [STEP_W-1:0] STEP_COMMIT = 4'd12;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LETTER,
    OP_HI,
    OP_LO,
    OP_COMMIT
  } op_t;

  typedef enum logic [2:0] {
    KIND_FREQ = 3'd0,
    KIND_PULSE = 3'd1,
    KIND_SUPPLY = 3'd2,
    KIND_LOAD = 3'd3,
    KIND_UNKNOWN = 3'd4
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [3:0] rd_addr;
    op_t op;
    logic [2:0] byte_idx;
    logic jmp_short;
    logic last;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic [3:0] rd_addr;
    op_t op;
    logic [2:0] byte_idx;
  } ctrl_t;

  typedef struct packed {
    logic short_cmd;
    logic out_free;
  } stat_t;

  // microprogram: read address issued this step, action on data read last step
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      4'd0: w = '{4'd0, OP_NONE, 3'd0, 1'b0, 1'b0, 4'd0};
      4'd1: w = '{4'd1, OP_LETTER, 3'd0, 1'b0, 1'b0, 4'd0};
      4'd2: w = '{4'd2, OP_HI, 3'd0, 1'b0, 1'b0, 4'd0};
      4'd3: w = '{4'd3, OP_LO, 3'd0, 1'b0, 1'b0, 4'd0};
      4'd4: w = '{4'd4, OP_HI, 3'd0, 1'b0, 1'b0, 4'd0};
      4'd5: w = '{4'd5, OP_LO, 3'd1, 1'b1, 1'b0, STEP_COMMIT};
      4'd6: w = '{4'd6, OP_HI, 3'd0, 1'b0, 1'b0, 4'd0};
      4'd7: w = '{4'd7, OP_LO, 3'd2, 1'b0, 1'b0, 4'd0};
      4'd8: w = '{4'd8, OP_HI, 3'd0, 1'b0, 1'b0, 4'd0};
      4'd9: w = '{4'd9, OP_LO, 3'd3, 1'b0, 1'b0, 4'd0};
      4'd10: w = '{4'd10, OP_HI, 3'd0, 1'b0, 1'b0, 4'd0};
      4'd11: w = '{4'd0, OP_LO, 3'd4, 1'b0, 1'b0, 4'd0};
      4'd12: w = '{4'd0, OP_COMMIT, 3'd0, 1'b0, 1'b1, 4'd0};
      default: w = '{4'd0, OP_NONE, 3'd0, 1'b0, 1'b1, 4'd0};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] d_num;
    logic [7:0] d_up;
    logic [7:0] d_low;
    logic [3:0] r;
    d_num = c - 8'h30;
    d_up = c - 8'h37;
    d_low = c - 8'h57;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = d_num[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = d_up[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = d_low[3:0];
    end else begin
      r = 4'd0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/hcl_line_buf.sv =====
module hcl_line_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [7:0]            wr_data,
  input  logic                  clr,
  input  logic [3:0]            rd_addr,
  output logic [7:0]            rd_data
);
  import hcl_pkg::*;

  logic [7:0] mem [LINE_DEPTH];
  logic [LINE_DEPTH-1:0] valid;
  logic [IDX_W-1:0] fill;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0] mem_q;
  logic valid_q;
  logic room;

  assign room = {1'b0, fill} < (IDX_W+1)'(LINE_DEPTH - 1);
  assign rd_idx = IDX_W'(rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en && room) begin
      mem[fill] <= wr_data;
    end
    mem_q <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      fill <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid[rd_idx];
      if (clr) begin
        fill <= '0;
      end else if (wr_en && room) begin
        valid[fill] <= 1'b1;
        fill <= fill + IDX_W'(1);
      end
    end
  end

  assign rd_data = valid_q ? mem_q : 8'd0;

endmodule

// ===== rtl/hcl_sequencer.sv =====
module hcl_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  hcl_pkg::stat_t stat,
  output hcl_pkg::ctrl_t ctrl,
  output logic           busy
);
  import hcl_pkg::*;

  state_t state;
  state_t state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  uword_t uw;

  assign uw = ucode(step);

  always_comb begin
    state_next = state;
    step_next = step;
    unique case (state)
      ST_IDLE: begin
        step_next = '0;
        if (start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (uw.last) begin
          if (stat.out_free) begin
            state_next = ST_IDLE;
          end
        end else if (uw.jmp_short && stat.short_cmd) begin
          step_next = uw.target;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl.rd_addr = uw.rd_addr;
    ctrl.byte_idx = uw.byte_idx;
    ctrl.op = OP_NONE;
    busy = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ctrl.op = OP_NONE;
      end
      ST_RUN: begin
        busy = 1'b1;
        if (!(uw.last && !stat.out_free)) begin
          ctrl.op = uw.op;
        end
      end
      default: begin
        ctrl.op = OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end

endmodule

// ===== rtl/hcl_datapath.sv =====
module hcl_datapath (
  input  logic           clk,
  input  logic           rst,
  input  hcl_pkg::ctrl_t ctrl,
  input  logic [7:0]     rd_data,
  input  logic           out_ready,
  output hcl_pkg::stat_t stat,
  output logic           out_valid,
  output logic [2:0]     command_kind,
  output logic           accepted,
  output logic [31:0]    frequency_value,
  output logic [31:0]    pulse_value,
  output logic [7:0]     supply_level,
  output logic [7:0]     load_level,
  output logic [7:0]     supply_compare,
  output logic [7:0]     load_compare
);
  import hcl_pkg::*;

  logic [7:0] letter;
  logic [3:0] hi_nib;
  logic [7:0] pair_bytes [5];
  logic [31:0] freq;
  logic [31:0] pulse;
  logic [7:0] supply;
  logic [7:0] load;
  logic [31:0] freq_next;
  logic [31:0] pulse_next;
  logic [7:0] supply_next;
  logic [7:0] load_next;
  kind_t kind;
  logic ok;
  logic word_ok;
  logic level_ok;
  logic [31:0] word;

  assign stat.short_cmd = (letter == CMD_SUPPLY) || (letter == CMD_LOAD);
  assign stat.out_free = !out_valid || out_ready;

  assign word = {pair_bytes[3], pair_bytes[2], pair_bytes[1], pair_bytes[0]};
  assign word_ok = (pair_bytes[0] ^ pair_bytes[1] ^ pair_bytes[2] ^ pair_bytes[3])
                   == pair_bytes[4];
  assign level_ok = (pair_bytes[0] ^ SMALL_CHECK) == pair_bytes[1];

  always_comb begin
    freq_next = freq;
    pulse_next = pulse;
    supply_next = supply;
    load_next = load;
    kind = KIND_UNKNOWN;
    ok = 1'b0;
    unique case (letter)
      CMD_FREQ: begin
        kind = KIND_FREQ;
        ok = word_ok;
        if (word_ok) begin
          freq_next = word;
        end
      end
      CMD_PULSE: begin
        kind = KIND_PULSE;
        ok = word_ok;
        if (word_ok) begin
          pulse_next = word;
        end
      end
      CMD_SUPPLY: begin
        kind = KIND_SUPPLY;
        ok = level_ok;
        if (level_ok) begin
          supply_next = pair_bytes[0];
        end
      end
      CMD_LOAD: begin
        kind = KIND_LOAD;
        ok = level_ok;
        if (level_ok) begin
          load_next = pair_bytes[0];
        end
      end
      default: begin
        kind = KIND_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LETTER: begin
        letter <= rd_data;
      end
      OP_HI: begin
        hi_nib <= hex_digit(rd_data);
      end
      OP_LO: begin
        pair_bytes[ctrl.byte_idx] <= {hi_nib, hex_digit(rd_data)};
      end
      OP_COMMIT: begin
        command_kind <= kind;
        accepted <= ok;
        frequency_value <= freq_next;
        pulse_value <= pulse_next;
        supply_level <= supply_next;
        load_level <= load_next;
        supply_compare <= LEVEL_MAX - supply_next;
        load_compare <= LEVEL_MAX - load_next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freq <= FREQ_RESET;
      pulse <= PULSE_RESET;
      supply <= LEVEL_RESET;
      load <= LEVEL_RESET;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.op == OP_COMMIT) begin
        freq <= freq_next;
        pulse <= pulse_next;
        supply <= supply_next;
        load <= load_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register must be free when a line is committed
  assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_COMMIT |-> !out_valid || out_ready)
    else $error("commit while result register is full");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> command_kind != KIND_UNKNOWN)
    else $error("unknown command reported as accepted");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> frequency_value == freq && pulse_value == pulse &&
      supply_level == supply && load_level == load)
    else $error("result does not match settings");

endmodule

// ===== rtl/hex_command_line_parser.sv =====
// Hex command line parser. Data bytes (anything but newline) are stored in a
// one-cycle transaction each; up to LINE_DEPTH-1 bytes of a line are kept and
// later ones dropped. A newline starts a microprogram that reads the line
// buffer through its single registered read port, one position per cycle:
// 'f', 't' and unknown letters read five hex pairs, 'u' and 'l' only two;
// the commit waits for out_ready if the previous result is still
// held. in_ready is low while the program runs. The buffer is cleared at
// reset through per-entry valid bits, so no clearing pass is needed. Each
// newline yields one result transaction with the command kind, the
// checksum outcome and all current settings with their PWM compare values.
module hex_command_line_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  command_kind,
  output logic        accepted,
  output logic [31:0] frequency_value,
  output logic [31:0] pulse_value,
  output logic [7:0]  supply_level,
  output logic [7:0]  load_level,
  output logic [7:0]  supply_compare,
  output logic [7:0]  load_compare
);
  import hcl_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic busy;
  logic in_take;
  logic is_newline;
  logic [7:0] rd_data;

  assign in_ready = !busy;
  assign in_take = in_valid && in_ready;
  assign is_newline = rx_byte == NEWLINE;

  hcl_line_buf u_buf (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_take && !is_newline),
    .wr_data (rx_byte),
    .clr     (in_take && is_newline),
    .rd_addr (ctrl.rd_addr),
    .rd_data (rd_data)
  );

  hcl_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (in_take && is_newline),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  hcl_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .rd_data         (rd_data),
    .out_ready       (out_ready),
    .stat            (stat),
    .out_valid       (out_valid),
    .command_kind    (command_kind),
    .accepted        (accepted),
    .frequency_value (frequency_value),
    .pulse_value     (pulse_value),
    .supply_level    (supply_level),
    .load_level      (load_level),
    .supply_compare  (supply_compare),
    .load_compare    (load_compare)
  );

endmodule
